// ===== design/bfps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfps_pkg
// Shared types and constants of the flash program / bank select sequencer.
// ----------------------------------------------------------------------------
package bfps_pkg;

  // request codes
  localparam logic [1:0] REQ_PROGRAM = 2'd0;
  localparam logic [1:0] REQ_ROM     = 2'd1;
  localparam logic [1:0] REQ_RAM     = 2'd2;

  // bank controller codes
  localparam logic [1:0] KIND_MBC1 = 2'd0;
  localparam logic [1:0] KIND_MBC3 = 2'd1;
  localparam logic [1:0] KIND_MBC5 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MAPPER_KIND = 2'd0;
  localparam logic [1:0] CFG_LARGE_RAM   = 2'd1;

  localparam int BANK_BYTES = 16384;
  localparam int BANK_SHIFT = $clog2(BANK_BYTES);

  localparam int ADDR_W = 23;
  localparam int BANK_W = 9;
  localparam int BUS_W  = 16;

  // bus addresses and command bytes
  localparam logic [15:0] ADDR_CMD1  = 16'h5555;
  localparam logic [15:0] ADDR_CMD2  = 16'h2AAA;
  localparam logic [15:0] ADDR_BANKL = 16'h2000;
  localparam logic [15:0] ADDR_BANKH = 16'h3000;
  localparam logic [15:0] ADDR_UPPER = 16'h4000;
  localparam logic [7:0]  DATA_UNLOCK1 = 8'hAA;
  localparam logic [7:0]  DATA_UNLOCK2 = 8'h55;
  localparam logic [7:0]  DATA_PROGRAM = 8'hA0;
  localparam logic [7:0]  MBC1_LOW_MASK = 8'h1F;

  // write slots of one request, in bus order
  localparam int NSLOTS = 10;
  localparam int SLOT_W = $clog2(NSLOTS);
  localparam logic [SLOT_W-1:0] SLOT_SEL1_A = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_SEL1_B = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_UNLK1  = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_UNLK2  = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_SEL2_A = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_SEL2_B = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_PGM    = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_BANK_A = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_BANK_B = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_DATA   = 4'd9;

  // command queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // up to two mapper register writes of one bank select
  typedef struct packed {
    logic        v1;
    logic        v2;
    logic [15:0] a1;
    logic [7:0]  d1;
    logic [15:0] a2;
    logic [7:0]  d2;
  } sel_t;

  // one decoded request
  typedef struct packed {
    logic [NSLOTS-1:0] mask;
    sel_t              sel1;
    sel_t              selb;
    logic [15:0]       fin_addr;
    logic [7:0]        fin_data;
  } desc_t;

endpackage

`default_nettype wire

// ===== design/bfps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfps_front
// Holds the configuration registers and decodes a request into a write plan.
// ----------------------------------------------------------------------------
module bfps_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [1:0]                cfg_data,
  input  wire logic                      accept,
  input  wire logic [1:0]                req_type,
  input  wire logic [bfps_pkg::ADDR_W-1:0] flash_addr,
  input  wire logic [7:0]                byte_value,
  input  wire logic [bfps_pkg::BANK_W-1:0] bank_number,
  output logic                           push,
  output bfps_pkg::desc_t                desc
);
  import bfps_pkg::*;

  logic [1:0] mapper_kind;
  logic       large_ram_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_kind    <= KIND_MBC1;
      large_ram_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAPPER_KIND: mapper_kind    <= cfg_data;
        CFG_LARGE_RAM:   large_ram_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic sel_t rom_select(input logic [1:0] kind, input logic big_ram,
                                      input logic [BANK_W-1:0] bank);
    sel_t s;
    s = '0;
    if (bank != '0) begin
      unique case (kind)
        KIND_MBC5: begin
          s.v1 = 1'b1; s.a1 = ADDR_BANKL; s.d1 = bank[7:0];
          s.v2 = 1'b1; s.a2 = ADDR_BANKH; s.d2 = {7'd0, bank[8]};
        end
        KIND_MBC1: begin
          if (big_ram) begin
            s.v1 = 1'b1; s.a1 = ADDR_BANKH; s.d1 = bank[7:0];
          end else begin
            s.v1 = 1'b1; s.a1 = ADDR_BANKH; s.d1 = bank[7:0] & MBC1_LOW_MASK;
            s.v2 = 1'b1; s.a2 = ADDR_UPPER; s.d2 = 8'(bank >> 5);
          end
        end
        KIND_MBC3: begin
          s.v1 = 1'b1; s.a1 = ADDR_BANKL; s.d1 = bank[7:0];
        end
        default: ;
      endcase
    end
    return s;
  endfunction

  sel_t                            sel_one;
  sel_t                            sel_ram;
  logic [BANK_W-1:0]               addr_bank;
  logic                            addr_high;

  assign addr_bank = flash_addr[ADDR_W-1:BANK_SHIFT];
  assign addr_high = (addr_bank != '0);
  assign sel_one   = rom_select(mapper_kind, large_ram_mode, BANK_W'(1));

  always_comb begin
    sel_ram = '0;
    if (mapper_kind == KIND_MBC5 || mapper_kind == KIND_MBC3 ||
        (mapper_kind == KIND_MBC1 && large_ram_mode)) begin
      sel_ram.v1 = 1'b1;
      sel_ram.a1 = ADDR_UPPER;
      sel_ram.d1 = bank_number[7:0];
    end
  end

  always_comb begin
    desc          = '0;
    desc.sel1     = sel_one;
    desc.fin_data = byte_value;
    desc.fin_addr = {addr_high ? 2'b01 : flash_addr[15:14], flash_addr[13:0]};
    unique case (req_type)
      REQ_PROGRAM: begin
        desc.selb                   = addr_high ? rom_select(mapper_kind, large_ram_mode,
                                                             addr_bank) : '0;
        desc.mask[SLOT_SEL1_A]      = sel_one.v1;
        desc.mask[SLOT_SEL1_B]      = sel_one.v2;
        desc.mask[SLOT_UNLK1]       = 1'b1;
        desc.mask[SLOT_UNLK2]       = 1'b1;
        desc.mask[SLOT_SEL2_A]      = sel_one.v1;
        desc.mask[SLOT_SEL2_B]      = sel_one.v2;
        desc.mask[SLOT_PGM]         = 1'b1;
        desc.mask[SLOT_BANK_A]      = desc.selb.v1;
        desc.mask[SLOT_BANK_B]      = desc.selb.v2;
        desc.mask[SLOT_DATA]        = 1'b1;
      end
      REQ_ROM: begin
        desc.selb              = rom_select(mapper_kind, large_ram_mode, bank_number);
        desc.mask[SLOT_BANK_A] = desc.selb.v1;
        desc.mask[SLOT_BANK_B] = desc.selb.v2;
      end
      REQ_RAM: begin
        desc.selb              = sel_ram;
        desc.mask[SLOT_BANK_A] = sel_ram.v1;
      end
      default: ;
    endcase
  end

  // requests that write nothing are dropped here
  assign push = accept && (desc.mask != '0);

endmodule

`default_nettype wire

// ===== design/bfps_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfps_queue
// Short FIFO of decoded requests between decoder and sequencer.
// ----------------------------------------------------------------------------
module bfps_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bfps_pkg::desc_t wr_data,
  input  wire logic            pop,
  output bfps_pkg::desc_t      rd_data,
  output logic                 full,
  output logic                 nonempty
);
  import bfps_pkg::*;

  desc_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !nonempty))
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
                               (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");
`endif

endmodule

`default_nettype wire

// ===== design/bfps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfps_back
// Walks the write plan of one request, one bus write per cycle.
// ----------------------------------------------------------------------------
module bfps_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bfps_pkg::desc_t q_data,
  input  wire logic            q_nonempty,
  output logic                 pop,
  output logic                 strobe,
  output logic [15:0]          bus_addr,
  output logic [7:0]           bus_data,
  output logic                 strobe_kind,
  output logic                 last_write
);
  import bfps_pkg::*;

  desc_t              cur;
  logic [NSLOTS-1:0]  mask;
  logic [NSLOTS-1:0]  low;
  logic [NSLOTS-1:0]  mask_next;
  logic [SLOT_W-1:0]  slot;

  assign low       = mask & (~mask + 1'b1);
  assign mask_next = mask & ~low;

  always_comb begin
    slot = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (low[i]) begin
        slot = slot | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    bus_addr    = cur.fin_addr;
    bus_data    = cur.fin_data;
    strobe_kind = 1'b1;
    unique case (slot)
      SLOT_SEL1_A, SLOT_SEL2_A: begin
        bus_addr = cur.sel1.a1; bus_data = cur.sel1.d1; strobe_kind = 1'b0;
      end
      SLOT_SEL1_B, SLOT_SEL2_B: begin
        bus_addr = cur.sel1.a2; bus_data = cur.sel1.d2; strobe_kind = 1'b0;
      end
      SLOT_UNLK1: begin
        bus_addr = ADDR_CMD1; bus_data = DATA_UNLOCK1;
      end
      SLOT_UNLK2: begin
        bus_addr = ADDR_CMD2; bus_data = DATA_UNLOCK2;
      end
      SLOT_PGM: begin
        bus_addr = ADDR_CMD1; bus_data = DATA_PROGRAM;
      end
      SLOT_BANK_A: begin
        bus_addr = cur.selb.a1; bus_data = cur.selb.d1; strobe_kind = 1'b0;
      end
      SLOT_BANK_B: begin
        bus_addr = cur.selb.a2; bus_data = cur.selb.d2; strobe_kind = 1'b0;
      end
      default: ;
    endcase
  end

  assign strobe     = (mask != '0);
  assign last_write = strobe && (mask_next == '0);
  // fetch the next plan in the cycle the current one finishes, or when idle
  assign pop        = q_nonempty && (mask_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (pop) begin
      mask <= q_data.mask;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

`ifndef SYNTHESIS
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
                                 (strobe && !last_write) |=> strobe)
    else $error("request writes not contiguous");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
                                      (last_write && !q_nonempty) |=> !strobe)
    else $error("write after last with empty queue");
  a_last_single: assert property (@(posedge clk) disable iff (rst)
                                  last_write |-> $onehot(mask))
    else $error("last write with writes pending");
`endif

endmodule

`default_nettype wire

// ===== design/banked_flash_program_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// banked_flash_program_sequencer_core
// Turns program / bank select requests into ordered cartridge bus writes.
//
//  channel   handshake                 payload
//  request   start, busy               req_type, flash_addr, byte_value, bank_number
//  write     strobe (no back-pressure) bus_addr, bus_data, strobe_kind, last_write
//  config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
//  One bus write per cycle; a request makes as many writes as its plan holds
//  (1 to 10), set by the sequencer walking its write plan.
//  First write goes out after the plan is queued and then loaded into the write mask.
//  A two-entry plan queue lets requests be taken while writes go out; busy
//  is high only while that queue is full.
//  rst (synchronous) clears the queue, the sequencer and the config registers.
// ----------------------------------------------------------------------------
module banked_flash_program_sequencer_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  req_type,
  input  wire logic [bfps_pkg::ADDR_W-1:0] flash_addr,
  input  wire logic [7:0]                  byte_value,
  input  wire logic [bfps_pkg::BANK_W-1:0] bank_number,
  output logic                             strobe,
  output logic [15:0]                      bus_addr,
  output logic [7:0]                       bus_data,
  output logic                             strobe_kind,
  output logic                             last_write,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [1:0]                  cfg_data
);
  import bfps_pkg::*;

  logic  q_full;
  logic  q_nonempty;
  logic  push;
  logic  pop;
  desc_t front_desc;
  desc_t q_desc;

  assign busy      = q_full;
  assign cfg_ready = 1'b1;

  bfps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (start && !q_full),
    .req_type    (req_type),
    .flash_addr  (flash_addr),
    .byte_value  (byte_value),
    .bank_number (bank_number),
    .push        (push),
    .desc        (front_desc)
  );

  bfps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (front_desc),
    .pop      (pop),
    .rd_data  (q_desc),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  bfps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_desc),
    .q_nonempty  (q_nonempty),
    .pop         (pop),
    .strobe      (strobe),
    .bus_addr    (bus_addr),
    .bus_data    (bus_data),
    .strobe_kind (strobe_kind),
    .last_write  (last_write)
  );

endmodule

`default_nettype wire
